@@ sv/sts_pkg.sv @@
package sts_pkg;

    // Payload widths of the request and result channels
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned COUNT_W = 9;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // Request commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } search_state_t;

endpackage

@@ sv/sts_req_if.sv @@
interface sts_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [sts_pkg::INDEX_W-1:0]         entry_index;
    logic signed [sts_pkg::DATA_W-1:0]   data_value;

    modport source (output valid, output command, output entry_index, output data_value,
                    input ready);
    modport sink   (input valid, input command, input entry_index, input data_value,
                    output ready);
endinterface

@@ sv/sts_res_if.sv @@
interface sts_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [sts_pkg::POS_W-1:0]   position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

@@ sv/sts_cfg_regs.sv @@
module sts_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sts_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [sts_pkg::COUNT_W-1:0]     entry_count
);

    logic [sts_pkg::COUNT_W-1:0] count_reg;
    logic [sts_pkg::COUNT_W-1:0] count_next;
    logic                        sel_count;

    // Decode the word index; low byte bits are ignored
    assign sel_count = (paddr[2] == sts_pkg::REG_ENTRY_COUNT);

    // Update the entry count on a completed write
    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && pready && sel_count)
        begin
            count_next = pwdata[sts_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Return the register value on a read, zero elsewhere
    always_comb
    begin
        prdata = '0;
        if (sel_count)
        begin
            prdata = sts_pkg::APB_DATA_W'(count_reg);
        end
    end

    assign pready      = 1'b1;
    assign entry_count = count_reg;

endmodule

@@ sv/sts_table_ram.sv @@
module sts_table_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [sts_pkg::DATA_W-1:0]  wr_data,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [sts_pkg::DATA_W-1:0]  rd_data
);

    logic signed [sts_pkg::DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/sts_search.sv @@
module sts_search #(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned AW          = 8,
    parameter int unsigned CW          = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sts_req_if.sink                            req,
    sts_res_if.source                          res,
    input  logic [sts_pkg::COUNT_W-1:0]        entry_count,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic signed [sts_pkg::DATA_W-1:0]  wr_data,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  logic signed [sts_pkg::DATA_W-1:0]  rd_data
);

    sts_pkg::search_state_t state_reg, state_next;

    logic [CW-1:0]                      lo_reg, lo_next;
    logic [CW-1:0]                      hx_reg, hx_next;
    logic [AW-1:0]                      mid_reg, mid_next;
    logic signed [sts_pkg::DATA_W-1:0]  key_reg, key_next;
    logic                               hit_reg, hit_next;
    logic                               res_valid_reg, res_valid_next;
    logic                               found_reg, found_next;
    logic [sts_pkg::POS_W-1:0]          position_reg, position_next;

    logic [CW-1:0]  span;
    logic [CW:0]    mid_sum;
    logic [AW-1:0]  mid;
    logic [CW-1:0]  mid_plus;
    logic           accept;

    // Clamp the searched range to the table depth
    always_comb
    begin
        if (32'(entry_count) > 32'(TABLE_DEPTH))
        begin
            span = CW'(TABLE_DEPTH);
        end
        else
        begin
            span = CW'(entry_count);
        end
    end

    // Midpoint of the inclusive range [lo, hx - 1]
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hx_reg} - (CW+1)'(1);
    assign mid      = AW'(mid_sum >> 1);
    assign mid_plus = CW'(mid_reg) + CW'(1);

    assign req.ready = (state_reg == sts_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Write requests go straight to the table
    assign wr_en   = accept && (req.command == sts_pkg::CMD_WRITE)
                     && (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = AW'(req.entry_index);
    assign wr_data = req.data_value;

    // Probe read address
    assign rd_en   = (state_reg == sts_pkg::ST_READ);
    assign rd_addr = mid;

    // Sequencer: read the midpoint, compare, narrow the bounds
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hx_next        = hx_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        position_next  = position_reg;

        // Drop the result once taken
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            sts_pkg::ST_IDLE:
            begin
                if (accept && (req.command == sts_pkg::CMD_SEARCH))
                begin
                    key_next = req.data_value;
                    lo_next  = '0;
                    hx_next  = span;
                    hit_next = 1'b0;
                    if (span != '0)
                    begin
                        state_next = sts_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = sts_pkg::ST_DONE;
                    end
                end
            end
            sts_pkg::ST_READ:
            begin
                mid_next   = mid;
                state_next = sts_pkg::ST_CMP;
            end
            sts_pkg::ST_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = sts_pkg::ST_DONE;
                end
                else
                begin
                    if (rd_data > key_reg)
                    begin
                        hx_next = CW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = mid_plus;
                    end
                    if (lo_next < hx_next)
                    begin
                        state_next = sts_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = sts_pkg::ST_DONE;
                    end
                end
            end
            sts_pkg::ST_DONE:
            begin
                // Hold until the output slot is free
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    found_next     = hit_reg;
                    position_next  = hit_reg ? sts_pkg::POS_W'(mid_reg) : '0;
                    state_next     = sts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sts_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hx_reg       <= hx_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    assign res.valid    = res_valid_reg;
    assign res.found    = found_reg;
    assign res.position = position_reg;

endmodule

@@ sv/sorted_table_binary_search.sv @@
// Sorted-table binary search. A write request (command 0) stores data_value at
// entry_index in a one-port-read, one-port-write table memory and gives no
// result; indexes at or beyond TABLE_DEPTH are dropped. A search request
// (command 1) runs a binary search for data_value over the first entry_count
// entries (APB register at byte address 0, clamped to TABLE_DEPTH) and gives
// one result: found and the low 8 bits of the matching position, or found 0
// and position 0. Entries must be loaded in ascending order before they are
// searched. A write is taken in the idle state and goes straight to the table.
// Each search probe passes through a read state, which issues the registered
// memory read, and a compare state; the result is posted from a done state, and
// an empty range goes from idle straight to done. One search is in flight at a
// time; a finished result waits in an output register while the next request
// is taken.
module sorted_table_binary_search #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sts_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    sts_req_if.sink                         req,
    sts_res_if.source                       res
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [sts_pkg::COUNT_W-1:0]        entry_count;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic signed [sts_pkg::DATA_W-1:0]  wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic signed [sts_pkg::DATA_W-1:0]  rd_data;

    sts_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_count (entry_count)
    );

    sts_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sts_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .entry_count (entry_count),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

endmodule

@@ dv/sorted_table_binary_search_tb.sv @@
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;

    import sts_pkg::*;

    localparam int unsigned TABLE_DEPTH    = 256;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam int unsigned PRESSURE_HOLD  = 400;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SEARCHES_PER_PHASE = 56;
    localparam int unsigned N_PHASES       = 16;
    localparam int unsigned N_DIRECTED     = 28;

    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = APB_ADDR_W'({REG_ENTRY_COUNT, 2'b00});
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE       = APB_ADDR_W'({1'b1, 2'b00});

    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;

    localparam int unsigned PHASE_COUNTS [N_PHASES] =
        '{256, 511, 3, 1, 0, 17, 5, 40, 2, 9, 257, 12, 6, 31, 4, 100};

    typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;
    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
    } search_result_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   cmd;
        logic [APB_ADDR_W-1:0]  addr;
        logic [INDEX_W-1:0]     idx;
        logic [DATA_W-1:0]      value;
        logic                   typed;
        logic                   found;
        logic [POS_W-1:0]       pos;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    sts_req_if req_ch ();
    sts_res_if res_ch ();

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    // Shadow copy of the table and the count register
    logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
    logic [COUNT_W-1:0]       shadow_count = '0;

    search_result_t pending_results [$];
    pace_t          pace = PACE_NONE;
    int unsigned    error_count = 0;
    int unsigned    hold_count = 0;
    stim_row_t      directed_rows [N_DIRECTED];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Probe the shadow table exactly as the block does
    function automatic search_result_t binary_probe(input logic signed [DATA_W-1:0] key);
        search_result_t r;
        int lo;
        int hi;
        int mid;
        int span;
        r = '0;
        span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        lo = 0;
        hi = span - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == key)
            begin
                r.found = 1'b1;
                r.position = POS_W'(mid);
                break;
            end
            if (shadow_table[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    function automatic bit sender_pauses();
        case (pace)
            PACE_SENDER: return $urandom_range(99, 0) < 48;
            PACE_BOTH:   return $urandom_range(99, 0) < 36;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (pace)
            PACE_RECEIVER: return $urandom_range(99, 0) < 48;
            PACE_BOTH:     return $urandom_range(99, 0) < 36;
            default:       return 1'b0;
        endcase
    endfunction

    // Offer one request, hold it until accepted, then record what it should give
    task automatic send_request(input logic cmd, input logic [INDEX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] val, input bit typed,
                                input logic found, input logic [POS_W-1:0] pos);
        if (sender_pauses())
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while (sender_pauses());
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.entry_index <= idx;
        req_ch.data_value  <= val;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (cmd == CMD_WRITE)
            shadow_table[idx] = val;
        else if (typed)
            pending_results.push_back('{found: found, position: pos});
        else
            pending_results.push_back(binary_probe(val));
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB, then read the count back
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] readback;
        drain_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == ADDR_ENTRY_COUNT)
            shadow_count = data[COUNT_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_ENTRY_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(shadow_count))
            report_mismatch($sformatf("entry_count readback %0h, want %0h",
                                      readback, shadow_count));
    endtask

    // One random phase: set the count, load a sorted prefix, then search it
    task automatic run_phase(input int unsigned phase);
        int unsigned count_val;
        int unsigned span;
        int unsigned style;
        int unsigned step_cap;
        int unsigned pick;
        int unsigned probe_ix;
        longint acc;
        logic [31:0] rnd;
        logic signed [DATA_W-1:0] key;
        count_val = PHASE_COUNTS[phase];
        span = (count_val > TABLE_DEPTH) ? TABLE_DEPTH : count_val;
        pace = pace_t'(phase % 4);
        if (phase % 5 == 2)
            write_register(ADDR_SPARE, $urandom);
        rnd = $urandom;
        write_register(ADDR_ENTRY_COUNT, {rnd[31:COUNT_W], COUNT_W'(count_val)});

        // Load ascending entries unless a full table is already in place
        if ((span < TABLE_DEPTH || phase == 0) && span > 0)
        begin
            style = $urandom_range(2, 0);
            step_cap = (style == 0) ? 32'hffff_ffff / span : (style == 1) ? 3 : 1000;
            acc = (style == 0) ? longint'(DATA_MIN) + longint'($urandom_range(step_cap, 0))
                               : longint'($signed($urandom));
            if ($urandom_range(3, 0) == 0)
                acc = longint'(DATA_MIN);
            for (int k = 0; k < int'(span); k++)
            begin
                if (k == int'(span) - 1 && $urandom_range(3, 0) == 0)
                    acc = longint'(DATA_MAX);
                if (acc > longint'(DATA_MAX))
                    acc = longint'(DATA_MAX);
                send_request(CMD_WRITE, INDEX_W'(k), DATA_W'(acc), 1'b0, 1'b0, '0);
                acc += longint'($urandom_range(step_cap, 0));
            end
        end

        // Let the result side block for a long stretch while requests keep coming
        if (phase == 0)
            hold_count++;

        for (int s = 0; s < int'(SEARCHES_PER_PHASE); s++)
        begin
            if ($urandom_range(9, 0) == 0)
                send_request(CMD_WRITE, INDEX_W'($urandom), $urandom, 1'b0, 1'b0, '0);
            pick = $urandom_range(99, 0);
            probe_ix = (span > 0) ? $urandom_range(span - 1, 0) : 0;
            if (span > 0 && pick < 55)
                key = shadow_table[probe_ix];
            else if (span > 0 && pick < 65)
                key = shadow_table[probe_ix] + 32'sd1;
            else if (span > 0 && pick < 75)
                key = shadow_table[probe_ix] - 32'sd1;
            else if (pick < 85)
            begin
                case ($urandom_range(3, 0))
                    0: key = DATA_MIN;
                    1: key = DATA_MAX;
                    2: key = -32'sd1;
                    default: key = '0;
                endcase
            end
            else
                key = $urandom;
            send_request(CMD_SEARCH, INDEX_W'($urandom), key, 1'b0, 1'b0, '0);
        end
    endtask

    // Result side: check each result against the oldest expectation, then pace ready
    initial
    begin : result_side
        search_result_t want;
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                              res_ch.found, res_ch.position));
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                                                  res_ch.found, want.found));
                    if (res_ch.position !== want.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  res_ch.position, want.position));
                end
            end
            if (hold_seen != hold_count)
            begin
                hold_seen = hold_count;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !receiver_stalls();
        end
    end

    // Watchdog: end the run after too many cycles with no handshake
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || psel === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_WRITE;
        req_ch.entry_index <= '0;
        req_ch.data_value  <= '0;

        // kind, cmd, addr, idx, value, typed, found, position
        directed_rows = '{
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'h00, 32'h0, 1'b1, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'hff, DATA_MIN, 1'b1, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd0, DATA_MIN, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd1, -32'sd5, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd2, 32'sd0, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd3, 32'sd7, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd4, DATA_MAX, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd255, -32'sd1, 1'b0, 1'b0, 8'd0},
            '{ROW_CONFIG, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd0, 32'd5, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd9, DATA_MIN, 1'b1, 1'b1, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, DATA_MAX, 1'b1, 1'b1, 8'd4},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, 32'sd0, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, -32'sd5, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, 32'sd7, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, -32'sd1, 1'b1, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, -32'sd6, 1'b1, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, 32'sd8, 1'b1, 1'b0, 8'd0},
            '{ROW_CONFIG, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd0, 32'd0, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, 32'sd7, 1'b1, 1'b0, 8'd0},
            '{ROW_CONFIG, CMD_WRITE, ADDR_SPARE, 8'd0, 32'd3, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, DATA_MIN, 1'b1, 1'b0, 8'd0},
            '{ROW_CONFIG, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd0, 32'hffff_fe01, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, -32'sd5, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd2, -32'sd100, 1'b0, 1'b0, 8'd0},
            '{ROW_CONFIG, CMD_WRITE, ADDR_ENTRY_COUNT, 8'd0, 32'd5, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, -32'sd100, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, 32'sd0, 1'b0, 1'b0, 8'd0},
            '{ROW_REQUEST, CMD_SEARCH, ADDR_ENTRY_COUNT, 8'd0, DATA_MIN, 1'b0, 1'b0, 8'd0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at full rate
        pace = PACE_NONE;
        for (int r = 0; r < int'(N_DIRECTED); r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CONFIG)
                write_register(row.addr, row.value);
            else
                send_request(row.cmd, row.idx, row.value, row.typed, row.found, row.pos);
        end

        for (int p = 0; p < int'(N_PHASES); p++)
            run_phase(p);

        drain_block();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sts_pkg.sv
sv/sts_req_if.sv
sv/sts_res_if.sv
sv/sts_cfg_regs.sv
sv/sts_table_ram.sv
sv/sts_search.sv
sv/sorted_table_binary_search.sv
dv/sorted_table_binary_search_tb.sv
